### design/zspd_pkg.sv
// shared types and codes for the zero-suppressed pixel decoder
`default_nettype none

package zspd_pkg;

  // frame status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_ABORT = 2'd2;

  // word position within a frame
  localparam logic [2:0] POS_SENSOR     = 3'd0;
  localparam logic [2:0] POS_HDR_LAST   = 3'd3;
  localparam logic [2:0] POS_FIRST_DATA = 3'd4;
  localparam logic [2:0] POS_LATER      = 3'd5;

  typedef struct packed {
    logic [15:0] data_word;
    logic        frame_last;
    logic [5:0]  start_frame;
    logic [9:0]  time_offset;
  } in_item_t;

  typedef struct packed {
    logic       hit_valid;
    logic [5:0] hit_sensor;
    logic [9:0] hit_row;
    logic [7:0] hit_column;
    logic [7:0] hit_charge;
    logic [5:0] hit_start_frame;
    logic [9:0] hit_time_offset;
    logic       dup_warning;
    logic [1:0] frame_status;
    logic       frame_end;
  } result_t;

endpackage

`default_nettype wire

### design/zspd_decode.sv
// frame state and per-word decode logic
`default_nettype none

module zspd_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire zspd_pkg::in_item_t item_i,
  output zspd_pkg::result_t      res_o
);

  logic [2:0]  pos_q, pos_d;
  logic [5:0]  sensor_q, sensor_d;
  logic [1:0]  chip_q, chip_d;
  logic [9:0]  row_even_q, row_even_d;
  logic        row_seen_q, row_seen_d;
  logic        aborted_q, aborted_d;
  logic [15:0] prev_q;

  logic [15:0] w;
  logic        frame_start;
  logic        hit;

  assign w           = item_i.data_word;
  assign frame_start = (pos_q == zspd_pkg::POS_SENSOR);

  always_comb begin
    sensor_d   = frame_start ? w[7:2] : sensor_q;
    chip_d     = frame_start ? w[1:0] : chip_q;
    row_even_d = frame_start ? 10'd0 : row_even_q;
    row_seen_d = frame_start ? 1'b0 : row_seen_q;
    aborted_d  = frame_start ? 1'b0 : aborted_q;
    hit        = 1'b0;

    if (pos_q >= zspd_pkg::POS_FIRST_DATA && !aborted_d) begin
      if (!w[15]) begin
        // row word: even row part, common-mode bits dropped
        row_even_d = {w[14:6], 1'b0};
        row_seen_d = 1'b1;
      end else if (!row_seen_d) begin
        aborted_d = 1'b1;
      end else begin
        hit = 1'b1;
      end
    end

    if (item_i.frame_last) begin
      pos_d = zspd_pkg::POS_SENSOR;
    end else if (pos_q < zspd_pkg::POS_LATER) begin
      pos_d = pos_q + 3'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_comb begin
    res_o = '0;
    res_o.hit_valid = hit;
    if (hit) begin
      res_o.hit_sensor      = sensor_d;
      res_o.hit_row         = {row_even_d[9:1], w[14]};
      res_o.hit_column      = {chip_d, w[13:8]};
      res_o.hit_charge      = w[7:0];
      res_o.hit_start_frame = item_i.start_frame;
      res_o.hit_time_offset = item_i.time_offset;
    end
    res_o.dup_warning = (pos_q == zspd_pkg::POS_HDR_LAST ||
                         pos_q == zspd_pkg::POS_FIRST_DATA) && (w == prev_q);
    if (aborted_d) begin
      res_o.frame_status = zspd_pkg::STATUS_ABORT;
    end else if (item_i.frame_last && pos_q < zspd_pkg::POS_HDR_LAST) begin
      res_o.frame_status = zspd_pkg::STATUS_SHORT;
    end else begin
      res_o.frame_status = zspd_pkg::STATUS_OK;
    end
    res_o.frame_end = item_i.frame_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= zspd_pkg::POS_SENSOR;
      sensor_q   <= '0;
      chip_q     <= '0;
      row_even_q <= '0;
      row_seen_q <= 1'b0;
      aborted_q  <= 1'b0;
      prev_q     <= '0;
    end else if (advance_i) begin
      pos_q      <= pos_d;
      sensor_q   <= sensor_d;
      chip_q     <= chip_d;
      row_even_q <= row_even_d;
      row_seen_q <= row_seen_d;
      aborted_q  <= aborted_d;
      prev_q     <= w;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= zspd_pkg::POS_LATER)
    else $error("word position beyond saturation");

  a_last_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.frame_last |=> pos_q == zspd_pkg::POS_SENSOR)
    else $error("frame end did not rewind word position");

  a_abort_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aborted_q && !frame_start |-> res_o.frame_status == zspd_pkg::STATUS_ABORT)
    else $error("aborted frame reported non-abort status");

endmodule

`default_nettype wire

### design/zero_suppressed_pixel_decoder.sv
// top level of the zero-suppressed pixel frame decoder
// an accepted item waits in the input register; its result goes into the output register
// throughput: one item per cycle unless stalled; one result per item, a single decode pass
// the input register and the output register each advance when the stage after is free
// reset: asynchronous active-low rst_ni clears both valid flags and the frame state
// after reset the next item is taken as word 0 of a new frame
`default_nettype none

module zero_suppressed_pixel_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] data_word_i,
  input  wire logic        frame_last_i,
  input  wire logic [5:0]  start_frame_i,
  input  wire logic [9:0]  time_offset_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             hit_valid_o,
  output logic [5:0]       hit_sensor_o,
  output logic [9:0]       hit_row_o,
  output logic [7:0]       hit_column_o,
  output logic [7:0]       hit_charge_o,
  output logic [5:0]       hit_start_frame_o,
  output logic [9:0]       hit_time_offset_o,
  output logic             dup_warning_o,
  output logic [1:0]       frame_status_o,
  output logic             frame_end_o
);

  // input register stage
  logic               in_vld_q;
  zspd_pkg::in_item_t in_item_q;

  // output register stage
  logic               out_vld_q;
  zspd_pkg::result_t  res_q;
  zspd_pkg::result_t  res_d;

  logic out_free;  // output register can take a new result
  logic in_free;   // input register can take a new item
  logic advance;   // decoded item moves into the output register

  assign out_free = !out_vld_q || !out_stall_i;
  assign advance  = in_vld_q && out_free;
  assign in_free  = !in_vld_q || out_free;

  assign in_stall_o = !in_free;

  // frame state lives in the decoder and steps only when an item is committed
  zspd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .res_o     (res_d)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_item_q.data_word   <= data_word_i;
      in_item_q.frame_last  <= frame_last_i;
      in_item_q.start_frame <= start_frame_i;
      in_item_q.time_offset <= time_offset_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign hit_valid_o       = res_q.hit_valid;
  assign hit_sensor_o      = res_q.hit_sensor;
  assign hit_row_o         = res_q.hit_row;
  assign hit_column_o      = res_q.hit_column;
  assign hit_charge_o      = res_q.hit_charge;
  assign hit_start_frame_o = res_q.hit_start_frame;
  assign hit_time_offset_o = res_q.hit_time_offset;
  assign dup_warning_o     = res_q.dup_warning;
  assign frame_status_o    = res_q.frame_status;
  assign frame_end_o       = res_q.frame_end;

  // a hit only ever comes from a healthy frame
  a_hit_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.hit_valid |-> res_q.frame_status == zspd_pkg::STATUS_OK)
    else $error("hit reported with bad frame status");

  // short-frame status is only given on the frame's last item
  a_short_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.frame_status == zspd_pkg::STATUS_SHORT |-> res_q.frame_end)
    else $error("short-frame status without frame end");

  // hit fields are cleared when the item is not a hit
  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.hit_valid |-> res_q.hit_row == '0 && res_q.hit_column == '0 &&
    res_q.hit_charge == '0 && res_q.hit_sensor == '0)
    else $error("hit fields not cleared on non-hit item");

  // an item waiting in the input stage moves on once the output stage is free
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_vld_q |=> out_vld_q)
    else $error("decoded item not moved into output register");

endmodule

`default_nettype wire
